### hdl/sequence_reorder_buffer_defines.svh
// ----------------------------------------------------------------------------
// sequence reorder buffer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_REORDER_BUFFER_DEFINES_SVH
`define SEQUENCE_REORDER_BUFFER_DEFINES_SVH

// same-cycle implication under reset
`define SRB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define SRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/srb_pkg.sv
// ----------------------------------------------------------------------------
// srb_pkg
// types, constants and helpers shared by the sequence reorder buffer
// ----------------------------------------------------------------------------
`default_nettype none

package srb_pkg;

  localparam int Window   = 16;
  localparam int SlotW    = $clog2(Window);
  localparam int PayloadW = 32;
  localparam int SeqW     = 64;
  localparam int StatusW  = 3;

  typedef enum logic [StatusW-1:0] {
    ST_RELEASED = 3'd0,
    ST_HELD     = 3'd1,
    ST_OLD      = 3'd2,
    ST_DUP      = 3'd3,
    ST_BEYOND   = 3'd4
  } status_e;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_e;

  // classified request handed from front to back
  typedef struct packed {
    status_e             kind;
    logic [SlotW-1:0]    off;
    logic [PayloadW-1:0] payload;
    logic [SeqW-1:0]     seq_low;
    logic [SeqW-1:0]     seq_high;
  } cmd_t;

  typedef struct packed {
    status_e             status;
    logic [PayloadW-1:0] payload;
    logic [SeqW-1:0]     seq_low;
    logic [SeqW-1:0]     seq_high;
    logic                last;
  } result_t;

  // window view exported by the back part
  typedef struct packed {
    logic [SeqW-1:0]   exp_low;
    logic [SeqW-1:0]   exp_high;
    logic [Window-1:0] valid;
    logic              done;
  } win_state_t;

  // slot index addition modulo the window size
  function automatic logic [SlotW-1:0] slot_add(logic [SlotW-1:0] a, logic [SlotW-1:0] b);
    logic [SlotW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (SlotW+1)'(Window)) begin
      sum = sum - (SlotW+1)'(Window);
    end
    return sum[SlotW-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/srb_res_fifo.sv
// ----------------------------------------------------------------------------
// srb_res_fifo
// small result queue between the back part and the result ports
// ----------------------------------------------------------------------------
`default_nettype none

module srb_res_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire srb_pkg::result_t data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output srb_pkg::result_t      data_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  srb_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d;
  logic [PtrW-1:0]  rd_q, rd_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + PtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (PtrW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### hdl/srb_front.sv
// ----------------------------------------------------------------------------
// srb_front
// takes one message, classifies it against the window and queues the request
// ----------------------------------------------------------------------------
`default_nettype none

module srb_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push_i,
  input  wire logic [srb_pkg::SeqW-1:0]        seq_low_i,
  input  wire logic [srb_pkg::SeqW-1:0]        seq_high_i,
  input  wire logic [srb_pkg::PayloadW-1:0]    payload_i,
  output logic                                 full_o,
  input  wire srb_pkg::win_state_t             win_i,
  output logic                                 cmd_valid_o,
  output srb_pkg::cmd_t                        cmd_o,
  input  wire logic                            cmd_pop_i
);

  localparam int SeqW     = srb_pkg::SeqW;
  localparam int SlotW    = srb_pkg::SlotW;
  localparam int PayloadW = srb_pkg::PayloadW;
  localparam int CqDepth  = 2;
  localparam int CqPtrW   = $clog2(CqDepth);

  logic                busy_q, busy_d;
  logic                item_vld_q, item_vld_d;
  logic [SeqW-1:0]     item_low_q, item_high_q;
  logic [PayloadW-1:0] item_pl_q;

  srb_pkg::cmd_t       cq_mem_q [CqDepth];
  logic [CqPtrW-1:0]   cq_wr_q, cq_rd_q;
  logic [CqPtrW:0]     cq_cnt_q, cq_cnt_d;

  logic                accept, cq_push, cq_pop, cq_full;
  logic [SeqW:0]       diff_lo, diff_hi;
  logic                is_old, is_beyond;
  srb_pkg::cmd_t       cmd_new;

  // one message in flight: the window is settled before the next is classified
  assign full_o  = busy_q && !win_i.done;
  assign accept  = push_i && !full_o;
  assign cq_full = (cq_cnt_q == (CqPtrW+1)'(CqDepth));
  assign cq_push = item_vld_q && !cq_full;
  assign cq_pop  = cmd_pop_i && cmd_valid_o;

  assign cmd_valid_o = (cq_cnt_q != '0);
  assign cmd_o       = cq_mem_q[cq_rd_q];

  always_comb begin
    diff_lo   = {1'b0, item_low_q} - {1'b0, win_i.exp_low};
    diff_hi   = {1'b0, item_high_q} - {1'b0, win_i.exp_high}
                - {{SeqW{1'b0}}, diff_lo[SeqW]};
    is_old    = diff_hi[SeqW];
    is_beyond = (diff_hi[SeqW-1:0] != '0) || (diff_lo[SeqW-1:0] >= SeqW'(srb_pkg::Window));

    cmd_new.off      = diff_lo[SlotW-1:0];
    cmd_new.payload  = item_pl_q;
    cmd_new.seq_low  = item_low_q;
    cmd_new.seq_high = item_high_q;
    if (is_old) begin
      cmd_new.kind = srb_pkg::ST_OLD;
    end else if (is_beyond) begin
      cmd_new.kind = srb_pkg::ST_BEYOND;
    end else if (win_i.valid[diff_lo[SlotW-1:0]]) begin
      cmd_new.kind = srb_pkg::ST_DUP;
    end else if (diff_lo[SlotW-1:0] == '0) begin
      cmd_new.kind = srb_pkg::ST_RELEASED;
    end else begin
      cmd_new.kind = srb_pkg::ST_HELD;
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (win_i.done) begin
      busy_d = 1'b0;
    end

    item_vld_d = item_vld_q;
    if (accept) begin
      item_vld_d = 1'b1;
    end else if (cq_push) begin
      item_vld_d = 1'b0;
    end

    cq_cnt_d = cq_cnt_q;
    if (cq_push && !cq_pop) begin
      cq_cnt_d = cq_cnt_q + (CqPtrW+1)'(1);
    end else if (cq_pop && !cq_push) begin
      cq_cnt_d = cq_cnt_q - (CqPtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      item_vld_q <= 1'b0;
      cq_wr_q    <= '0;
      cq_rd_q    <= '0;
      cq_cnt_q   <= '0;
    end else begin
      busy_q     <= busy_d;
      item_vld_q <= item_vld_d;
      cq_cnt_q   <= cq_cnt_d;
      if (cq_push) begin
        cq_wr_q <= cq_wr_q + CqPtrW'(1);
      end
      if (cq_pop) begin
        cq_rd_q <= cq_rd_q + CqPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_low_q  <= seq_low_i;
      item_high_q <= seq_high_i;
      item_pl_q   <= payload_i;
    end
    if (cq_push) begin
      cq_mem_q[cq_wr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

### hdl/srb_back.sv
// ----------------------------------------------------------------------------
// srb_back
// owns the window and expected number, stores held messages, drains runs
// ----------------------------------------------------------------------------
`default_nettype none

module srb_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cmd_valid_i,
  input  wire srb_pkg::cmd_t       cmd_i,
  output logic                     cmd_pop_o,
  input  wire logic                res_full_i,
  output logic                     res_push_o,
  output srb_pkg::result_t         res_o,
  output srb_pkg::win_state_t      win_o
);

  localparam int Window   = srb_pkg::Window;
  localparam int SlotW    = srb_pkg::SlotW;
  localparam int SeqW     = srb_pkg::SeqW;
  localparam int PayloadW = srb_pkg::PayloadW;

  srb_pkg::back_state_e state_q, state_d;
  logic [SlotW-1:0]     base_q;
  logic [Window-1:0]    valid_q;
  logic [PayloadW-1:0]  pl_mem_q [Window];
  logic [PayloadW-1:0]  run_pl_q;
  logic [SeqW-1:0]      exp_low_q, exp_high_q;

  logic [SlotW-1:0]     nxt1, hold_idx;
  logic                 last_run;
  logic                 advance, hold_wr, done;
  logic [Window-1:0]    valid_rot;

  // the window is kept circular: logical slot 0 sits at base_q
  assign nxt1     = srb_pkg::slot_add(base_q, SlotW'(1));
  assign hold_idx = srb_pkg::slot_add(base_q, cmd_i.off);
  assign last_run = !valid_q[nxt1];

  always_comb begin
    for (int i = 0; i < Window; i++) begin
      valid_rot[i] = valid_q[srb_pkg::slot_add(base_q, SlotW'(i))];
    end
  end

  assign win_o.exp_low  = exp_low_q;
  assign win_o.exp_high = exp_high_q;
  assign win_o.valid    = valid_rot;
  assign win_o.done     = done;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      srb_pkg::BK_IDLE: begin
        if (cmd_valid_i && !res_full_i && cmd_i.kind == srb_pkg::ST_RELEASED && !last_run) begin
          state_d = srb_pkg::BK_RUN;
        end
      end
      srb_pkg::BK_RUN: begin
        if (!res_full_i && last_run) begin
          state_d = srb_pkg::BK_IDLE;
        end
      end
      default: state_d = srb_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    advance    = 1'b0;
    hold_wr    = 1'b0;
    done       = 1'b0;
    case (state_q)
      srb_pkg::BK_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o      = 1'b1;
          res_push_o     = 1'b1;
          res_o.status   = cmd_i.kind;
          res_o.payload  = cmd_i.payload;
          res_o.seq_low  = cmd_i.seq_low;
          res_o.seq_high = cmd_i.seq_high;
          res_o.last     = 1'b1;
          done           = 1'b1;
          if (cmd_i.kind == srb_pkg::ST_RELEASED) begin
            // the new message fills slot 0 and goes straight out
            advance    = 1'b1;
            res_o.last = last_run;
            done       = last_run;
          end else if (cmd_i.kind == srb_pkg::ST_HELD) begin
            hold_wr = 1'b1;
          end
        end
      end
      srb_pkg::BK_RUN: begin
        if (!res_full_i) begin
          res_push_o     = 1'b1;
          res_o.status   = srb_pkg::ST_RELEASED;
          res_o.payload  = run_pl_q;
          res_o.seq_low  = exp_low_q;
          res_o.seq_high = exp_high_q;
          res_o.last     = last_run;
          advance        = 1'b1;
          done           = last_run;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= srb_pkg::BK_IDLE;
      base_q     <= '0;
      valid_q    <= '0;
      exp_low_q  <= '0;
      exp_high_q <= '0;
    end else begin
      state_q <= state_d;
      if (advance) begin
        valid_q[base_q] <= 1'b0;
        base_q          <= nxt1;
        exp_low_q       <= exp_low_q + SeqW'(1);
        if (&exp_low_q) begin
          exp_high_q <= exp_high_q + SeqW'(1);
        end
      end
      if (hold_wr) begin
        valid_q[hold_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_wr) begin
      pl_mem_q[hold_idx] <= cmd_i.payload;
    end
    // fetch the payload of the slot that becomes the head
    if (advance) begin
      run_pl_q <= pl_mem_q[nxt1];
    end
  end

endmodule

`default_nettype wire

### hdl/sequence_reorder_buffer.sv
// ----------------------------------------------------------------------------
// sequence_reorder_buffer
// puts messages tagged with 128-bit sequence numbers back into order
// ----------------------------------------------------------------------------
// One message is in flight at a time. A message that is dropped or held gives
// one status result; one that completes a run of n held messages gives n + 1
// results, one per cycle out of the window while the result queue has room.
// The next push is taken once the last result goes to the queue. This pacing
// is set by the window lookup, which must see the state left by the previous
// message, and by the single release port of the window. Results wait in a
// four-entry queue, so a slow reader only stalls the buffer once it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module sequence_reorder_buffer (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic [srb_pkg::SeqW-1:0]           seq_low_i,
  input  wire logic [srb_pkg::SeqW-1:0]           seq_high_i,
  input  wire logic [srb_pkg::PayloadW-1:0]       payload_i,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic [srb_pkg::StatusW-1:0]             status_o,
  output logic [srb_pkg::PayloadW-1:0]            out_payload_o,
  output logic [srb_pkg::SeqW-1:0]                out_seq_low_o,
  output logic [srb_pkg::SeqW-1:0]                out_seq_high_o,
  output logic                                    last_o
);

  srb_pkg::win_state_t win;
  srb_pkg::cmd_t       cmd;
  srb_pkg::result_t    res_in, res_out;
  logic                cmd_valid, cmd_pop;
  logic                res_push, res_full;

  srb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .seq_low_i   (seq_low_i),
    .seq_high_i  (seq_high_i),
    .payload_i   (payload_i),
    .full_o      (full),
    .win_i       (win),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  srb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .win_o       (win)
  );

  srb_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_out)
  );

  assign status_o       = res_out.status;
  assign out_payload_o  = res_out.payload;
  assign out_seq_low_o  = res_out.seq_low;
  assign out_seq_high_o = res_out.seq_high;
  assign last_o         = res_out.last;

endmodule

`default_nettype wire

### hdl/srb_checker.sv
// ----------------------------------------------------------------------------
// srb_checker
// port-level checks for the sequence reorder buffer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "sequence_reorder_buffer_defines.svh"

module srb_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  input  wire logic                          full,
  input  wire logic                          empty,
  input  wire logic                          pop,
  input  wire logic [srb_pkg::StatusW-1:0]   status_o,
  input  wire logic [srb_pkg::PayloadW-1:0]  out_payload_o,
  input  wire logic [srb_pkg::SeqW-1:0]      out_seq_low_o,
  input  wire logic [srb_pkg::SeqW-1:0]      out_seq_high_o,
  input  wire logic                          last_o
);

  // a waiting result holds until it is taken
  `SRB_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, (!empty && !pop), (!empty && $stable(status_o) && $stable(out_payload_o) && $stable(out_seq_low_o) && $stable(out_seq_high_o) && $stable(last_o)), "result changed while waiting")

  // every status other than a release ends its run at once
  `SRB_ASSERT_NOW(a_single_last, clk_i, rst_ni, (!empty && status_o != srb_pkg::ST_RELEASED), last_o, "non-release result without last")

  // only one message is in flight, so a taken push closes the input
  `SRB_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, (push && !full), full, "input open right after a push")

endmodule

bind sequence_reorder_buffer srb_checker u_srb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .push           (push),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .status_o       (status_o),
  .out_payload_o  (out_payload_o),
  .out_seq_low_o  (out_seq_low_o),
  .out_seq_high_o (out_seq_high_o),
  .last_o         (last_o)
);

`default_nettype wire
